// ----- rtl/protobuf_record_stream_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the wire format decoder
// Immediate-style wrappers around concurrent checks, removed when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_RECORD_STREAM_DECODER_CORE_ASSERT_SVH
`define PROTOBUF_RECORD_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define PBD_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A consequence that must hold in the cycle after its trigger.
`define PBD_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBD_CHECK(lbl, clk, rst, prop, msg)
`define PBD_CHECK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/pbd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the wire format decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

  // Buffer size seen by the position counter and its saturation point.
  localparam longint unsigned BUFFER_BYTES = 64'd65536;
  localparam logic [16:0] POS_LIMIT =
    (BUFFER_BYTES > 64'h1FFFF) ? 17'h1FFFF : 17'(BUFFER_BYTES);

  // Default number of entries between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Wire types.
  localparam logic [2:0] WK_VARINT = 3'd0;
  localparam logic [2:0] WK_I64    = 3'd1;
  localparam logic [2:0] WK_LEN    = 3'd2;
  localparam logic [2:0] WK_I32    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_LONG      = 2'd2;
  localparam logic [1:0] ST_BAD_KIND  = 2'd3;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_VARINT = 3'd1,
    PH_FIXED  = 3'd2,
    PH_LENVAR = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DROP   = 3'd5
  } phase_t;

  // Input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [31:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] payload_value;
    logic [16:0] payload_start;
    logic [16:0] end_offset;
    logic [1:0]  status;
  } out_item_t;

  // Configuration write data.
  typedef struct packed {
    logic [15:0] start_offset;
  } cfg_item_t;

  // One classified byte with its buffer offset and the offset after it.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        final_byte;
    logic [16:0] cur;
    logic [16:0] nxt;
  } q_entry_t;

  // Front to queue.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  // Queue to back.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

`default_nettype wire

// ----- rtl/pbd_chan_if.sv -----
// ----------------------------------------------------------------------------
// pbd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbd_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/pbd_front.sv -----
// ----------------------------------------------------------------------------
// pbd_front
// Holds the start offset register and the position counter, and tags each
// accepted byte with its offset before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  pbd_chan_if.sink            cfg,
  input  wire logic           accept,
  input  wire pbd_pkg::in_item_t item,
  output pbd_pkg::q_push_t    push
);
  import pbd_pkg::*;

  logic [15:0] start_offset;
  logic [16:0] position;
  logic        fresh;
  logic [16:0] cur;
  logic [16:0] nxt;

  // The register is always writable.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
    end else if (cfg.valid) begin
      start_offset <= cfg.payload.start_offset;
    end
  end

  // The first byte of a buffer starts at the configured offset.
  always_comb begin
    cur = fresh ? {1'b0, start_offset} : position;
    nxt = (cur < POS_LIMIT) ? cur + 17'd1 : cur;
  end

  // Position advances per byte; the final byte arms the next buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      fresh    <= 1'b1;
    end else if (accept) begin
      position <= nxt;
      fresh    <= item.final_byte;
    end
  end

  always_comb begin
    push.valid            = accept;
    push.entry.data_byte  = item.data_byte;
    push.entry.final_byte = item.final_byte;
    push.entry.cur        = cur;
    push.entry.nxt        = nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/pbd_queue.sv -----
// ----------------------------------------------------------------------------
// pbd_queue
// Short first-in first-out queue between the front and the parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "protobuf_record_stream_decoder_core_assert.svh"

module pbd_queue #(
  parameter int DEPTH = pbd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pbd_pkg::q_push_t push,
  input  wire logic             pop,
  output pbd_pkg::q_head_t      head,
  output logic                  full
);
  import pbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            empty;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    head.valid = !empty;
    head.entry = slots[rd_ptr];
  end

  `PBD_CHECK(a_count_bound, clk, rst, count <= CW'(DEPTH), "queue count beyond depth")
  `PBD_CHECK(a_no_overflow, clk, rst, !(push.valid && full), "push into a full queue")
  `PBD_CHECK(a_no_underflow, clk, rst, !(pop && empty), "pop from an empty queue")

endmodule

`default_nettype wire

// ----- rtl/pbd_back.sv -----
// ----------------------------------------------------------------------------
// pbd_back
// Record parser: walks tag, varint, fixed, length and skipped payload bytes
// and loads each finished record or error into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "protobuf_record_stream_decoder_core_assert.svh"

module pbd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pbd_pkg::q_head_t head,
  output logic                  pop,
  pbd_chan_if.source            records
);
  import pbd_pkg::*;

  phase_t      phase, phase_next;
  logic [63:0] accumulator, accumulator_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [31:0] held_field, held_field_next;
  logic [2:0]  held_kind, held_kind_next;
  logic [63:0] remaining, remaining_next;
  logic [16:0] origin, origin_next;
  logic [16:0] mark, mark_next;

  out_item_t   res, res_next;
  logic        out_valid;
  logic        emit;

  logic [7:0]  b;
  logic [6:0]  vshamt;
  logic [5:0]  fshamt;
  logic [63:0] acc_v;
  logic        v_done;
  logic        v_long;

  function automatic out_item_t make_res(logic [31:0] fid, logic [2:0] kind,
                                         logic [63:0] val, logic [16:0] ps,
                                         logic [16:0] endo, logic [1:0] st);
    out_item_t r;
    r.field_id      = fid;
    r.wire_kind     = kind;
    r.payload_value = val;
    r.payload_start = ps;
    r.end_offset    = endo;
    r.status        = st;
    return r;
  endfunction

  // A byte is taken whenever the output register can take its result.
  assign pop = head.valid && (!out_valid || records.ready);

  // Varint step: seven value bits at offset seven times the octet count.
  always_comb begin
    b      = head.entry.data_byte;
    vshamt = 7'(byte_count) * 7'd7;
    fshamt = {byte_count[2:0], 3'b000};
    acc_v  = accumulator;
    if (vshamt < 7'd64) begin
      acc_v = accumulator | (64'(b[6:0]) << vshamt[5:0]);
    end
    v_done = !b[7];
    v_long = b[7] && (byte_count >= 4'd9);
  end

  // Phase sequencing and result selection.
  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    byte_count_next  = byte_count;
    held_field_next  = held_field;
    held_kind_next   = held_kind;
    remaining_next   = remaining;
    origin_next      = origin;
    mark_next        = mark;
    emit             = 1'b0;
    res_next         = '0;

    case (phase)
      PH_TAG: begin
        if (byte_count == 4'd0) begin
          mark_next = head.entry.cur;
        end
        accumulator_next = acc_v;
        if (v_long) begin
          emit       = 1'b1;
          res_next   = make_res('0, '0, '0, '0, mark_next, ST_LONG);
          phase_next = PH_DROP;
        end else if (v_done) begin
          held_field_next  = acc_v[34:3];
          held_kind_next   = acc_v[2:0];
          accumulator_next = '0;
          byte_count_next  = '0;
          mark_next        = head.entry.nxt;
          case (acc_v[2:0])
            WK_VARINT:       phase_next = PH_VARINT;
            WK_I64, WK_I32:  phase_next = PH_FIXED;
            WK_LEN:          phase_next = PH_LENVAR;
            default: begin
              emit       = 1'b1;
              res_next   = make_res(acc_v[34:3], acc_v[2:0], '0, '0,
                                    head.entry.nxt, ST_BAD_KIND);
              phase_next = PH_DROP;
            end
          endcase
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end

      PH_VARINT: begin
        accumulator_next = acc_v;
        if (v_long) begin
          emit       = 1'b1;
          res_next   = make_res(held_field, held_kind, '0, '0, mark, ST_LONG);
          phase_next = PH_DROP;
        end else if (v_done) begin
          emit     = 1'b1;
          res_next = make_res(held_field, held_kind, acc_v, '0,
                              head.entry.nxt, ST_OK);
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end

      PH_FIXED: begin
        accumulator_next = accumulator | (64'(b) << fshamt);
        byte_count_next  = byte_count + 4'd1;
        if (byte_count_next >= ((held_kind == WK_I64) ? 4'd8 : 4'd4)) begin
          emit     = 1'b1;
          res_next = make_res(held_field, held_kind, accumulator_next, '0,
                              head.entry.nxt, ST_OK);
        end
      end

      PH_LENVAR: begin
        accumulator_next = acc_v;
        if (v_long) begin
          emit       = 1'b1;
          res_next   = make_res(held_field, held_kind, '0, '0, mark, ST_LONG);
          phase_next = PH_DROP;
        end else if (v_done) begin
          remaining_next  = acc_v;
          origin_next     = head.entry.nxt;
          mark_next       = head.entry.nxt;
          byte_count_next = '0;
          if (acc_v == '0) begin
            // An empty payload completes the record with its length.
            emit     = 1'b1;
            res_next = make_res(held_field, held_kind, '0, head.entry.nxt,
                                head.entry.nxt, ST_OK);
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end

      PH_SKIP: begin
        remaining_next = remaining - 64'd1;
        if (remaining == 64'd1) begin
          emit     = 1'b1;
          res_next = make_res(held_field, held_kind, accumulator, origin,
                              head.entry.nxt, ST_OK);
        end
      end

      default: begin
      end
    endcase

    // The final byte reports an unfinished record as truncated.
    if (head.entry.final_byte && !emit && (phase_next != PH_DROP) &&
        !((phase_next == PH_TAG) && (byte_count_next == 4'd0))) begin
      emit = 1'b1;
      if (phase_next == PH_TAG) begin
        res_next = make_res('0, '0, '0, '0, mark_next, ST_TRUNCATED);
      end else begin
        res_next = make_res(held_field_next, held_kind_next, '0, '0, mark_next,
                            ST_TRUNCATED);
      end
    end

    // A completed record, or the end of the buffer, starts over at a tag.
    if ((emit && (phase_next != PH_DROP)) || head.entry.final_byte) begin
      phase_next       = PH_TAG;
      accumulator_next = '0;
      byte_count_next  = '0;
      held_field_next  = '0;
      held_kind_next   = '0;
      remaining_next   = '0;
      origin_next      = '0;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAG;
      accumulator <= '0;
      byte_count  <= '0;
      held_field  <= '0;
      held_kind   <= '0;
      remaining   <= '0;
      origin      <= '0;
      mark        <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      accumulator <= accumulator_next;
      byte_count  <= byte_count_next;
      held_field  <= held_field_next;
      held_kind   <= held_kind_next;
      remaining   <= remaining_next;
      origin      <= origin_next;
      mark        <= mark_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (records.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

  assign records.valid   = out_valid;
  assign records.payload = res;

  `PBD_CHECK(a_count_range, clk, rst, byte_count <= 4'd9, "octet count out of range")
  `PBD_CHECK(a_skip_nonzero, clk, rst, (phase != PH_SKIP) || (remaining != '0), "skip with nothing left")
  `PBD_CHECK_NEXT(a_final_restart, clk, rst, pop && head.entry.final_byte, (phase == PH_TAG) && (byte_count == 4'd0), "no restart after final byte")

endmodule

`default_nettype wire

// ----- rtl/protobuf_record_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// protobuf_record_stream_decoder_core
// Streaming Protocol Buffers wire format decoder, one octet per item.
// ----------------------------------------------------------------------------
// Takes one byte of the encoded buffer per cycle and returns one result per
// completed record (field, wire type, value or length, payload and end
// offsets) or per error (truncated record, varint over ten octets, bad wire
// type). Bytes are accepted back to back at one per cycle while the queue is
// not full; a result is registered onto the records channel when the parser
// takes the byte that completes it. A queue of QUEUE_DEPTH bytes sits between
// the offset counter and the parser, so while a result waits the queue fills
// up to QUEUE_DEPTH bytes before the input stalls; the parser takes one byte
// per cycle whenever the output register is free.
// The start offset register is loaded through cfg and is used from the first
// byte of the next buffer; write it only while the decoder is idle. After
// reset the decoder accepts bytes at once.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_record_stream_decoder_core #(
  parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pbd_chan_if.sink   cfg,
  pbd_chan_if.sink   bytes,
  pbd_chan_if.source records
);
  import pbd_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    pop;
  logic    q_full;
  logic    accept;
  in_item_t item;

  // Bytes enter while the queue has room.
  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && !q_full;
  assign item        = bytes.payload;

  pbd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .push   (push)
  );

  pbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  pbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .records (records)
  );

endmodule

`default_nettype wire
